>>> rtl/tdsu_pkg.sv
package tdsu_pkg;

    localparam logic [7:0] TICK_DIV_RESET = 8'd103;
    localparam logic [3:0] RX_FRAME_BITS  = 4'd9;
    localparam logic [3:0] TX_FRAME_BITS  = 4'd10;
    localparam logic [15:0] TX_IDLE       = 16'hFFFF;

    typedef enum logic [1:0] {
        TAKE_NONE = 2'd0,
        TAKE_DONE = 2'd1,
        TAKE_BUSY = 2'd2
    } t_take_status;

    typedef struct packed {
        t_take_status take_status;
        logic [7:0]   rx_data;
        logic         receiving;
    } t_rx_result;

endpackage

>>> rtl/timer_driven_soft_uart_top.sv
// Timer-driven 8N1 UART: every input item is one timer tick carrying the sampled
// receive line, an optional byte to send and an optional take request, and it
// yields exactly one result item. A new item is accepted every clock while
// o_in_ready is high; its result is captured in the output register on
// acceptance, and o_in_ready stays high while that register is empty or being
// taken this cycle. The bit period is the divider value plus one ticks; the
// divider must be written through i_cfg_we/i_cfg_data while idle (not enforced).
module timer_driven_soft_uart_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_rx_level,
    input  logic       i_send_valid,
    input  logic [7:0] i_send_byte,
    input  logic       i_take_request,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_tx_level,
    output logic       o_send_accepted,
    output logic [1:0] o_take_status,
    output logic [7:0] o_rx_data,
    output logic       o_receiving
);

    logic [7:0]  r_tick_div;
    logic [7:0]  r_tick_count, n_tick_count;
    logic [15:0] r_tx_shift, n_tx_shift;
    logic [3:0]  r_tx_bits_left, n_tx_bits_left;
    logic        r_tx_line, n_tx_line;
    logic        n_accepted;
    logic        r_out_valid;
    logic        r_send_accepted;
    tdsu_pkg::t_rx_result n_rx_result, r_rx_result;
    logic        in_fire;
    logic [7:0]  half;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign in_fire    = i_in_valid & o_in_ready;
    assign half       = {1'b0, r_tick_div[7:1]};

    tdsu_rx u_rx (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (in_fire),
        .i_rx_level     (i_rx_level),
        .i_take_request (i_take_request),
        .i_tick         (r_tick_count),
        .i_half         (half),
        .o_result       (n_rx_result)
    );

    always_comb begin
        n_tick_count   = r_tick_count + 8'd1;
        n_tx_shift     = r_tx_shift;
        n_tx_bits_left = r_tx_bits_left;
        n_tx_line      = r_tx_line;
        n_accepted     = 1'b0;

        if (r_tick_count >= r_tick_div) begin
            n_tick_count = 8'd0;
            n_tx_line    = r_tx_shift[0];
            n_tx_shift   = {1'b1, r_tx_shift[15:1]};
            if (r_tx_bits_left != 4'd0) begin
                n_tx_bits_left = r_tx_bits_left - 4'd1;
            end
        end

        if (i_send_valid && (n_tx_bits_left == 4'd0)) begin
            n_tx_shift     = {7'h7F, i_send_byte, 1'b0};
            n_tx_bits_left = tdsu_pkg::TX_FRAME_BITS;
            n_accepted     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_div <= tdsu_pkg::TICK_DIV_RESET;
        end else if (i_cfg_we) begin
            r_tick_div <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count   <= 8'd0;
            r_tx_shift     <= tdsu_pkg::TX_IDLE;
            r_tx_bits_left <= 4'd0;
            r_tx_line      <= 1'b1;
        end else if (in_fire) begin
            r_tick_count   <= n_tick_count;
            r_tx_shift     <= n_tx_shift;
            r_tx_bits_left <= n_tx_bits_left;
            r_tx_line      <= n_tx_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_send_accepted <= n_accepted;
            r_rx_result     <= n_rx_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_tx_level      = r_tx_line;
    assign o_send_accepted = r_send_accepted;
    assign o_take_status   = r_rx_result.take_status;
    assign o_rx_data       = r_rx_result.rx_data;
    assign o_receiving     = r_rx_result.receiving;

    a_send_loads_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && n_accepted |=> r_tx_bits_left == tdsu_pkg::TX_FRAME_BITS)
        else $error("accepted send did not load a full frame");

    a_tx_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_bits_left <= tdsu_pkg::TX_FRAME_BITS)
        else $error("transmit bit count out of range");

    a_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_fire |=> $stable(r_tick_count) && $stable(r_tx_shift))
        else $error("tick state advanced without an item");

endmodule

>>> rtl/tdsu_rx.sv
module tdsu_rx (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_rx_level,
    input  logic                  i_take_request,
    input  logic [7:0]            i_tick,
    input  logic [7:0]            i_half,
    output tdsu_pkg::t_rx_result  o_result
);

    logic [7:0] r_sample_point, n_sample_point;
    logic [7:0] r_rx_shift, n_rx_shift;
    logic [3:0] r_rx_bits_left, n_rx_bits_left;
    logic       r_edge_armed, n_edge_armed;
    logic       r_rx_previous;
    logic       falling;

    assign falling = r_rx_previous & ~i_rx_level;

    always_comb begin
        n_sample_point = r_sample_point;
        n_rx_shift     = r_rx_shift;
        n_rx_bits_left = r_rx_bits_left;
        n_edge_armed   = r_edge_armed;
        o_result.take_status = tdsu_pkg::TAKE_NONE;
        o_result.rx_data     = 8'd0;

        if (!r_edge_armed) begin
            if (i_tick == r_sample_point) begin
                n_rx_bits_left = r_rx_bits_left - 4'd1;
                if (n_rx_bits_left == 4'd0) begin
                    n_edge_armed = 1'b1;
                    n_rx_shift   = {i_rx_level, r_rx_shift[6:0]};
                end else begin
                    n_rx_shift   = {1'b0, i_rx_level, r_rx_shift[6:1]};
                end
            end
        end else if (falling) begin
            n_rx_bits_left = tdsu_pkg::RX_FRAME_BITS;
            n_rx_shift     = 8'd0;
            n_edge_armed   = 1'b0;
            if (i_tick < i_half) begin
                n_sample_point = i_tick + i_half;
            end else begin
                n_sample_point = i_tick - i_half;
            end
        end

        if (i_take_request && (n_rx_bits_left < tdsu_pkg::RX_FRAME_BITS)) begin
            if (n_rx_bits_left == 4'd0) begin
                o_result.take_status = tdsu_pkg::TAKE_DONE;
                o_result.rx_data     = n_rx_shift;
                n_rx_bits_left       = tdsu_pkg::RX_FRAME_BITS;
            end else begin
                o_result.take_status = tdsu_pkg::TAKE_BUSY;
            end
        end

        o_result.receiving = ~n_edge_armed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_point <= 8'd0;
            r_rx_shift     <= 8'd0;
            r_rx_bits_left <= tdsu_pkg::RX_FRAME_BITS;
            r_edge_armed   <= 1'b1;
            r_rx_previous  <= 1'b1;
        end else if (i_en) begin
            r_sample_point <= n_sample_point;
            r_rx_shift     <= n_rx_shift;
            r_rx_bits_left <= n_rx_bits_left;
            r_edge_armed   <= n_edge_armed;
            r_rx_previous  <= i_rx_level;
        end
    end

    a_armed_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_armed |-> (r_rx_bits_left == 4'd0) || (r_rx_bits_left == tdsu_pkg::RX_FRAME_BITS))
        else $error("armed receiver holds a partial bit count");

    a_rx_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_bits_left <= tdsu_pkg::RX_FRAME_BITS)
        else $error("receive bit count out of range");

endmodule

>>> dv/timer_driven_soft_uart_top_tb.sv
`timescale 1ns / 100ps

module timer_driven_soft_uart_top_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;

    typedef enum int {
        FLOW_STEADY,
        FLOW_SENDER_IDLE,
        FLOW_RECEIVER_STALL,
        FLOW_BOTH_IDLE
    } t_flow;

    typedef struct packed {
        logic                 tx_level;
        logic                 send_accepted;
        tdsu_pkg::t_rx_result rx;
    } t_tick_result;

    class uart_tick_scoreboard;
        logic [7:0]   divisor;
        logic [7:0]   tick;
        logic [7:0]   sample_at;
        logic [15:0]  tx_frame;
        logic [3:0]   tx_remaining;
        logic [7:0]   rx_bits;
        logic [3:0]   rx_remaining;
        logic         armed;
        logic         rx_last;
        logic         tx_pin;
        t_tick_result expected_ticks[$];
        int           fails;

        function new();
            divisor      = tdsu_pkg::TICK_DIV_RESET;
            tick         = '0;
            sample_at    = '0;
            tx_frame     = tdsu_pkg::TX_IDLE;
            tx_remaining = '0;
            rx_bits      = '0;
            rx_remaining = tdsu_pkg::RX_FRAME_BITS;
            armed        = 1'b1;
            rx_last      = 1'b1;
            tx_pin       = 1'b1;
            fails        = 0;
        endfunction

        function void set_divisor(input logic [7:0] value);
            divisor = value;
        endfunction

        function void note_tick(input logic rx, input logic send_req,
                                input logic [7:0] send_data, input logic take);
            logic [7:0]   t;
            logic [7:0]   half;
            logic         falling;
            t_tick_result res;
            t       = tick;
            half    = divisor >> 1;
            falling = rx_last && !rx;
            res     = '0;
            res.rx.take_status = tdsu_pkg::TAKE_NONE;
            rx_last = rx;

            if (!armed) begin
                if (t == sample_at) begin
                    if (rx)
                        rx_bits[7] = 1'b1;
                    rx_remaining = rx_remaining - 4'd1;
                    if (rx_remaining == 4'd0)
                        armed = 1'b1;
                    else
                        rx_bits = rx_bits >> 1;
                end
            end else if (falling) begin
                rx_remaining = tdsu_pkg::RX_FRAME_BITS;
                rx_bits      = '0;
                sample_at    = (t < half) ? t + half : t - half;
                armed        = 1'b0;
            end

            if (t >= divisor) begin
                tick     = '0;
                tx_pin   = tx_frame[0];
                tx_frame = {1'b1, tx_frame[15:1]};
                if (tx_remaining != 4'd0)
                    tx_remaining = tx_remaining - 4'd1;
            end else begin
                tick = t + 8'd1;
            end

            if (take && rx_remaining < tdsu_pkg::RX_FRAME_BITS) begin
                if (rx_remaining == 4'd0) begin
                    res.rx.take_status = tdsu_pkg::TAKE_DONE;
                    res.rx.rx_data     = rx_bits;
                    rx_remaining       = tdsu_pkg::RX_FRAME_BITS;
                end else begin
                    res.rx.take_status = tdsu_pkg::TAKE_BUSY;
                end
            end

            if (send_req && tx_remaining == 4'd0) begin
                tx_frame          = {7'h7F, send_data, 1'b0};
                tx_remaining      = tdsu_pkg::TX_FRAME_BITS;
                res.send_accepted = 1'b1;
            end

            res.tx_level     = tx_pin;
            res.rx.receiving = !armed;
            expected_ticks.push_back(res);
        endfunction

        function void check_result(input t_tick_result got);
            t_tick_result want;
            if (expected_ticks.size() == 0) begin
                if (fails < 10)
                    $display("unexpected result item: tx=%0b acc=%0b take=%0d data=%02h rcv=%0b",
                             got.tx_level, got.send_accepted, got.rx.take_status,
                             got.rx.rx_data, got.rx.receiving);
                fails++;
            end else begin
                want = expected_ticks.pop_front();
                if (got.tx_level !== want.tx_level
                        || got.send_accepted !== want.send_accepted
                        || got.rx.take_status !== want.rx.take_status
                        || got.rx.rx_data !== want.rx.rx_data
                        || got.rx.receiving !== want.rx.receiving) begin
                    if (fails < 10)
                        $display({"mismatch: expected tx=%0b acc=%0b take=%0d data=%02h rcv=%0b,",
                                  " got tx=%0b acc=%0b take=%0d data=%02h rcv=%0b"},
                                 want.tx_level, want.send_accepted, want.rx.take_status,
                                 want.rx.rx_data, want.rx.receiving,
                                 got.tx_level, got.send_accepted, got.rx.take_status,
                                 got.rx.rx_data, got.rx.receiving);
                    fails++;
                end
            end
        endfunction
    endclass

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_cfg_we       = 1'b0;
    logic [7:0] i_cfg_data     = '0;
    logic       i_in_valid     = 1'b0;
    logic       i_rx_level     = 1'b1;
    logic       i_send_valid   = 1'b0;
    logic [7:0] i_send_byte    = '0;
    logic       i_take_request = 1'b0;
    logic       i_out_ready    = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_tx_level;
    logic       o_send_accepted;
    logic [1:0] o_take_status;
    logic [7:0] o_rx_data;
    logic       o_receiving;

    uart_tick_scoreboard sb = new();
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          cycle_count        = 0;
    logic        line_plan[$];

    timer_driven_soft_uart_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_level     (i_rx_level),
        .i_send_valid   (i_send_valid),
        .i_send_byte    (i_send_byte),
        .i_take_request (i_take_request),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_tx_level     (o_tx_level),
        .o_send_accepted(o_send_accepted),
        .o_take_status  (o_take_status),
        .o_rx_data      (o_rx_data),
        .o_receiving    (o_receiving)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        t_tick_result got;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got.tx_level       = o_tx_level;
                got.send_accepted  = o_send_accepted;
                got.rx.take_status = tdsu_pkg::t_take_status'(o_take_status);
                got.rx.rx_data     = o_rx_data;
                got.rx.receiving   = o_receiving;
                sb.check_result(got);
            end
            if (i_in_valid && o_in_ready)
                sb.note_tick(i_rx_level, i_send_valid, i_send_byte, i_take_request);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic void set_flow(input t_flow mode);
        case (mode)
            FLOW_STEADY: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            FLOW_SENDER_IDLE: begin
                sender_idle_pct    = 81;
                receiver_stall_pct = 0;
            end
            FLOW_RECEIVER_STALL: begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 81;
            end
            default: begin
                sender_idle_pct    = 12;
                receiver_stall_pct = 12;
            end
        endcase
    endfunction

    // queue up the next stretch of receive line: mostly clean frames, some noise and runts
    function automatic void extend_line_plan(input int div);
        int         kind;
        int         len;
        int         k;
        logic [9:0] frame;
        kind = $urandom_range(99);
        if (kind < 75) begin
            repeat ($urandom_range(((div + 1) * 2 < 20) ? (div + 1) * 2 : 20))
                line_plan.push_back(1'b1);
            frame = {1'b1, 8'($urandom), 1'b0};
            for (k = 0; k < 10; k++) begin
                len = div + 1;
                if (div >= 3 && $urandom_range(3) == 0)
                    len = len - 1 + int'($urandom_range(2));
                repeat (len)
                    line_plan.push_back(frame[k]);
            end
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 8))
                line_plan.push_back(1'($urandom_range(1)));
        end else begin
            line_plan.push_back(1'b1);
            repeat ($urandom_range(1, div))
                line_plan.push_back(1'b0);
            repeat ((div + 1) * $urandom_range(1, 3))
                line_plan.push_back(1'b1);
        end
    endfunction

    task automatic drive_tick(input logic rx, input logic send_req,
                              input logic [7:0] send_data, input logic take);
        i_in_valid     <= 1'b1;
        i_rx_level     <= rx;
        i_send_valid   <= send_req;
        i_send_byte    <= send_data;
        i_take_request <= take;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drive_random_tick(input int div, input logic rx_idle);
        logic rx;
        if (rx_idle) begin
            rx = 1'b1;
        end else begin
            if (line_plan.size() == 0)
                extend_line_plan(div);
            rx = line_plan.pop_front();
        end
        drive_tick(rx, $urandom_range(99) < 10, 8'($urandom), $urandom_range(99) < 12);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.expected_ticks.size() != 0);
    endtask

    task automatic write_divisor(input logic [7:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_divisor(value);
    endtask

    initial begin
        int    div_lo[PHASES]      = '{15, 2, 3, 2, 7, 2, 3, 255};
        int    div_hi[PHASES]      = '{15, 2, 3, 10, 7, 2, 12, 255};
        int    phase_items[PHASES] = '{80, 80, 80, 80, 80, 80, 80, 100};
        t_flow phase_flow[PHASES]  = '{FLOW_STEADY, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL,
                                       FLOW_BOTH_IDLE, FLOW_STEADY, FLOW_RECEIVER_STALL,
                                       FLOW_SENDER_IDLE, FLOW_BOTH_IDLE};
        int    div;
        int    p;

        set_flow(FLOW_STEADY);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // half bit of 10 ticks; falling edge at tick 3 puts the sample point at 13
        write_divisor(8'd20);
        drive_tick(1'b1, 1'b0, 8'h00, 1'b1);
        drive_tick(1'b1, 1'b1, 8'h00, 1'b0);
        drive_tick(1'b1, 1'b1, 8'hFF, 1'b0);
        drive_tick(1'b0, 1'b0, 8'h00, 1'b0);
        drive_tick(1'b0, 1'b0, 8'h00, 1'b1);
        drive_tick(1'b1, 1'b0, 8'h00, 1'b0);
        drive_tick(1'b0, 1'b0, 8'h00, 1'b0);
        drive_tick(1'b1, 1'b1, 8'hA5, 1'b0);

        // counter now above divider, sample point out of reach: receiver stalls
        write_divisor(8'd4);
        drive_tick(1'b0, 1'b0, 8'h00, 1'b0);
        drive_tick(1'b1, 1'b0, 8'h00, 1'b1);
        drive_tick(1'b0, 1'b1, 8'h5A, 1'b0);
        drive_tick(1'b1, 1'b0, 8'h00, 1'b0);
        drive_tick(1'b0, 1'b0, 8'h00, 1'b1);
        drive_tick(1'b1, 1'b1, 8'hFF, 1'b0);

        // first random phase brings the stalled sample point back in reach
        for (p = 0; p < PHASES; p++) begin
            div = $urandom_range(div_hi[p], div_lo[p]);
            write_divisor(8'(div));
            set_flow(phase_flow[p]);
            line_plan.delete();
            repeat (phase_items[p])
                drive_random_tick(div, 1'b0);
            // hold the line high so any receive frame in flight completes before the divisor changes
            if (p != PHASES - 1)
                repeat (11 * (div + 1))
                    drive_random_tick(div, 1'b1);
        end

        set_flow(FLOW_STEADY);
        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.fails == 0 && sb.expected_ticks.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d failing items, %0d results missing", sb.fails,
                     sb.expected_ticks.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> timer_driven_soft_uart_top.f
rtl/tdsu_pkg.sv
rtl/tdsu_rx.sv
rtl/timer_driven_soft_uart_top.sv
dv/timer_driven_soft_uart_top_tb.sv
